FILE: design/dlpp_pkg.sv
// Shared types and defaults for the dual line point push block.
// No dependencies.
package dlpp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // {axis_is_y, angle_is_steep}
    typedef enum logic [1:0] {
        KIND_X_FLAT  = 2'b00,
        KIND_X_STEEP = 2'b01,
        KIND_Y_FLAT  = 2'b10,
        KIND_Y_STEEP = 2'b11
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  lam_zero;
        logic  n_zero;
        logic  neg;
        logic  horiz;
    } t_ctrl;

endpackage

FILE: design/dlpp_div_cell.sv
// One restoring-division cell: one quotient bit per word, passes the word on.
// Depends on dlpp_pkg.
module dlpp_div_cell #(
    parameter int FRAC_BITS = dlpp_pkg::FRAC_BITS_DEF,
    parameter int NQ_W      = 49,
    parameter int DATA_W    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dlpp_pkg::t_ctrl       i_ctrl,
    input  logic [FRAC_BITS:0]    i_lam,
    input  logic [FRAC_BITS:0]    i_rem,
    input  logic [NQ_W-1:0]       i_nq,
    input  logic [DATA_W-1:0]     i_data,
    output dlpp_pkg::t_ctrl       o_ctrl,
    output logic [FRAC_BITS:0]    o_lam,
    output logic [FRAC_BITS:0]    o_rem,
    output logic [NQ_W-1:0]       o_nq,
    output logic [DATA_W-1:0]     o_data
);
    import dlpp_pkg::*;

    logic [FRAC_BITS+1:0] trial;
    logic [FRAC_BITS+1:0] diff;
    logic                 ge;
    logic [FRAC_BITS:0]   n_rem;
    logic [NQ_W-1:0]      n_nq;

    t_ctrl                r_ctrl;
    logic [FRAC_BITS:0]   r_lam;
    logic [FRAC_BITS:0]   r_rem;
    logic [NQ_W-1:0]      r_nq;
    logic [DATA_W-1:0]    r_data;

    always_comb begin
        trial = {i_rem, i_nq[NQ_W-1]};
        diff  = trial - {1'b0, i_lam};
        ge    = (trial >= {1'b0, i_lam});
        n_rem = ge ? diff[FRAC_BITS:0] : trial[FRAC_BITS:0];
        n_nq  = {i_nq[NQ_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lam  <= i_lam;
        r_rem  <= n_rem;
        r_nq   <= n_nq;
        r_data <= i_data;
    end

    assign o_ctrl = r_ctrl;
    assign o_lam  = r_lam;
    assign o_rem  = r_rem;
    assign o_nq   = r_nq;
    assign o_data = r_data;

endmodule

FILE: design/dlpp_front.sv
// Front stages: operand select, lambda products, below test, rounded product.
// Depends on dlpp_pkg.
module dlpp_front #(
    parameter int COORD_WIDTH = dlpp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = dlpp_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_axis_is_y,
    input  logic                        i_angle_is_steep,
    input  logic [FRAC_BITS:0]          i_slope_param,
    input  logic [COORD_WIDTH-2:0]      i_offset_param,
    input  logic [COORD_WIDTH-1:0]      i_point_x,
    input  logic [COORD_WIDTH-1:0]      i_point_y,
    output dlpp_pkg::t_ctrl             o_ctrl,
    output logic [FRAC_BITS:0]          o_lam,
    output logic [COORD_WIDTH:0]        o_div_n,
    output logic [COORD_WIDTH-1:0]      o_px,
    output logic [COORD_WIDTH-1:0]      o_py,
    output logic [COORD_WIDTH-2:0]      o_mu,
    output logic [COORD_WIDTH+3:0]      o_mul
);
    import dlpp_pkg::*;

    localparam int EW = COORD_WIDTH + 2;
    localparam int PW = EW + FRAC_BITS + 2;
    localparam int MW = COORD_WIDTH + FRAC_BITS + 2;
    localparam int SW = COORD_WIDTH + 4;

    function automatic logic [COORD_WIDTH:0] mag(input logic signed [EW-1:0] a);
        logic signed [EW-1:0] m;
        m = a[EW-1] ? -a : a;
        return m[COORD_WIDTH:0];
    endfunction

    // operand select
    logic signed [EW-1:0] px_e, py_e, mu_e;
    logic signed [EW-1:0] mul_a, div_a, cmp_a, cmp_d;
    t_kind                kind;

    always_comb begin
        px_e = $signed({{2{i_point_x[COORD_WIDTH-1]}}, i_point_x});
        py_e = $signed({{2{i_point_y[COORD_WIDTH-1]}}, i_point_y});
        mu_e = $signed({3'b000, i_offset_param});
        kind = t_kind'({i_axis_is_y, i_angle_is_steep});
        unique case (kind)
            KIND_X_FLAT: begin
                cmp_a = py_e;         cmp_d = px_e - mu_e;
                mul_a = px_e - mu_e;  div_a = py_e;
            end
            KIND_X_STEEP: begin
                cmp_a = mu_e - px_e;  cmp_d = -py_e;
                mul_a = py_e;         div_a = px_e - mu_e;
            end
            KIND_Y_FLAT: begin
                cmp_a = py_e - mu_e;  cmp_d = px_e;
                mul_a = px_e;         div_a = py_e - mu_e;
            end
            KIND_Y_STEEP: begin
                cmp_a = -px_e;        cmp_d = mu_e - py_e;
                mul_a = py_e - mu_e;  div_a = px_e;
            end
            default: begin
                cmp_a = '0; cmp_d = '0; mul_a = '0; div_a = '0;
            end
        endcase
    end

    // stage 1
    logic                     r_s1_valid;
    t_kind                    r_s1_kind;
    logic [FRAC_BITS:0]       r_s1_lam;
    logic [COORD_WIDTH-2:0]   r_s1_mu;
    logic [COORD_WIDTH-1:0]   r_s1_px, r_s1_py;
    logic signed [EW-1:0]     r_s1_mul_a, r_s1_div_a, r_s1_cmp_a, r_s1_cmp_d;

    // stage 2
    logic                     r_s2_valid;
    t_kind                    r_s2_kind;
    logic [FRAC_BITS:0]       r_s2_lam;
    logic [COORD_WIDTH-2:0]   r_s2_mu;
    logic [COORD_WIDTH-1:0]   r_s2_px, r_s2_py;
    logic signed [EW-1:0]     r_s2_cmp_a;
    logic signed [PW-1:0]     r_s2_cmp_p;
    logic [MW-1:0]            r_s2_mul_p;
    logic                     r_s2_mul_neg;
    logic [COORD_WIDTH:0]     r_s2_div_n;
    logic                     r_s2_div_neg;

    // stage 3
    t_ctrl                    r_s3_ctrl;
    logic [FRAC_BITS:0]       r_s3_lam;
    logic [COORD_WIDTH:0]     r_s3_div_n;
    logic [COORD_WIDTH-1:0]   r_s3_px, r_s3_py;
    logic [COORD_WIDTH-2:0]   r_s3_mu;
    logic [SW-1:0]            r_s3_mul;

    logic signed [PW-1:0]     n_cmp_p;
    logic [MW-1:0]            n_mul_p;
    logic signed [PW-1:0]     lhs;
    logic [MW-1:0]            rounded;
    logic [COORD_WIDTH+1:0]   mul_r;
    logic [SW-1:0]            n_mul;
    t_ctrl                    n_ctrl;

    always_comb begin
        n_cmp_p = $signed({1'b0, r_s1_lam}) * r_s1_cmp_d;
        n_mul_p = MW'(mag(r_s1_mul_a)) * MW'(r_s1_lam);
    end

    always_comb begin
        lhs     = $signed({{2{r_s2_cmp_a[EW-1]}}, r_s2_cmp_a, {FRAC_BITS{1'b0}}});
        rounded = r_s2_mul_p + (MW'(1) << (FRAC_BITS - 1));
        mul_r   = rounded[MW-1:FRAC_BITS];
        n_mul   = r_s2_mul_neg ? (SW'(0) - {2'b00, mul_r}) : {2'b00, mul_r};
        n_ctrl.valid    = r_s2_valid;
        n_ctrl.kind     = r_s2_kind;
        n_ctrl.lam_zero = (r_s2_lam == '0);
        n_ctrl.n_zero   = (r_s2_div_n == '0);
        n_ctrl.neg      = r_s2_div_neg;
        n_ctrl.horiz    = (lhs >= r_s2_cmp_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_ctrl  <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_ctrl  <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind    <= kind;
        r_s1_lam     <= i_slope_param;
        r_s1_mu      <= i_offset_param;
        r_s1_px      <= i_point_x;
        r_s1_py      <= i_point_y;
        r_s1_mul_a   <= mul_a;
        r_s1_div_a   <= div_a;
        r_s1_cmp_a   <= cmp_a;
        r_s1_cmp_d   <= cmp_d;

        r_s2_kind    <= r_s1_kind;
        r_s2_lam     <= r_s1_lam;
        r_s2_mu      <= r_s1_mu;
        r_s2_px      <= r_s1_px;
        r_s2_py      <= r_s1_py;
        r_s2_cmp_a   <= r_s1_cmp_a;
        r_s2_cmp_p   <= n_cmp_p;
        r_s2_mul_p   <= n_mul_p;
        r_s2_mul_neg <= r_s1_mul_a[EW-1];
        r_s2_div_n   <= mag(r_s1_div_a);
        r_s2_div_neg <= r_s1_div_a[EW-1];

        r_s3_lam     <= r_s2_lam;
        r_s3_div_n   <= r_s2_div_n;
        r_s3_px      <= r_s2_px;
        r_s3_py      <= r_s2_py;
        r_s3_mu      <= r_s2_mu;
        r_s3_mul     <= n_mul;
    end

    assign o_ctrl  = r_s3_ctrl;
    assign o_lam   = r_s3_lam;
    assign o_div_n = r_s3_div_n;
    assign o_px    = r_s3_px;
    assign o_py    = r_s3_py;
    assign o_mu    = r_s3_mu;
    assign o_mul   = r_s3_mul;

endmodule

FILE: design/dual_line_point_push.sv
// Top level of the dual line point push block: front stages, divider chain, output stage.
// Depends on dlpp_pkg, dlpp_front, dlpp_div_cell.
//
// Fully pipelined: one word may start in every cycle and busy stays low. Each result
// appears on the o_ ports for one cycle with o_valid, after passing three front stages,
// the row of division cells (one quotient bit per cell) and one output register.
// Results cannot be held off and must be taken when o_valid is high.
module dual_line_point_push #(
    parameter int COORD_WIDTH = dlpp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = dlpp_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_axis_is_y,
    input  logic                   i_angle_is_steep,
    input  logic [FRAC_BITS:0]     i_slope_param,
    input  logic [COORD_WIDTH-2:0] i_offset_param,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    output logic                   o_valid,
    output logic [COORD_WIDTH-1:0] o_pushed_x,
    output logic [COORD_WIDTH-1:0] o_pushed_y,
    output logic [COORD_WIDTH-1:0] o_weighted_value,
    output logic                   o_went_horizontal,
    output logic                   o_zero_divide
);
    import dlpp_pkg::*;

    localparam int SW     = COORD_WIDTH + 4;
    localparam int NQ_W   = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int DATA_W = 3 * COORD_WIDTH - 1 + SW;
    localparam int LAT    = NQ_W + 4;

    localparam logic signed [SW-1:0] SMAX =
        $signed({{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] SMIN =
        $signed({{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}});

    function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return c[COORD_WIDTH-1:0];
    endfunction

    t_ctrl                  f_ctrl;
    logic [FRAC_BITS:0]     f_lam;
    logic [COORD_WIDTH:0]   f_div_n;
    logic [COORD_WIDTH-1:0] f_px, f_py;
    logic [COORD_WIDTH-2:0] f_mu;
    logic [SW-1:0]          f_mul;

    assign busy = 1'b0;

    dlpp_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (start && !busy),
        .i_axis_is_y      (i_axis_is_y),
        .i_angle_is_steep (i_angle_is_steep),
        .i_slope_param    (i_slope_param),
        .i_offset_param   (i_offset_param),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .o_ctrl           (f_ctrl),
        .o_lam            (f_lam),
        .o_div_n          (f_div_n),
        .o_px             (f_px),
        .o_py             (f_py),
        .o_mu             (f_mu),
        .o_mul            (f_mul)
    );

    t_ctrl              c_ctrl [NQ_W+1];
    logic [FRAC_BITS:0] c_lam  [NQ_W+1];
    logic [FRAC_BITS:0] c_rem  [NQ_W+1];
    logic [NQ_W-1:0]    c_nq   [NQ_W+1];
    logic [DATA_W-1:0]  c_data [NQ_W+1];

    assign c_ctrl[0] = f_ctrl;
    assign c_lam[0]  = f_lam;
    assign c_rem[0]  = '0;
    assign c_nq[0]   = {f_div_n, {FRAC_BITS{1'b0}}};
    assign c_data[0] = {f_px, f_py, f_mu, f_mul};

    for (genvar g = 0; g < NQ_W; g++) begin : g_cell
        dlpp_div_cell #(
            .FRAC_BITS (FRAC_BITS),
            .NQ_W      (NQ_W),
            .DATA_W    (DATA_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (c_ctrl[g]),
            .i_lam   (c_lam[g]),
            .i_rem   (c_rem[g]),
            .i_nq    (c_nq[g]),
            .i_data  (c_data[g]),
            .o_ctrl  (c_ctrl[g+1]),
            .o_lam   (c_lam[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_nq    (c_nq[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    // output stage
    t_ctrl                  e_ctrl;
    logic [COORD_WIDTH-1:0] e_px, e_py;
    logic [COORD_WIDTH-2:0] e_mu;
    logic [SW-1:0]          e_mul;
    logic                   rnd;
    logic [NQ_W:0]          q_r;
    logic [COORD_WIDTH:0]   d_mag;
    logic signed [SW-1:0]   d_s, m_s, px_s, py_s, mu_s, pm_s, qm_s;
    logic signed [SW-1:0]   rx, ry, w;

    always_comb begin
        e_ctrl = c_ctrl[NQ_W];
        {e_px, e_py, e_mu, e_mul} = c_data[NQ_W];
        rnd  = ({c_rem[NQ_W], 1'b0} >= {1'b0, c_lam[NQ_W]});
        q_r  = {1'b0, c_nq[NQ_W]} + (NQ_W+1)'(rnd);
        // quotient at or past 2^COORD_WIDTH saturates any result it reaches
        if (e_ctrl.n_zero) begin
            d_mag = '0;
        end else if (e_ctrl.lam_zero || (q_r >= ((NQ_W+1)'(1) << COORD_WIDTH))) begin
            d_mag = {1'b1, {COORD_WIDTH{1'b0}}};
        end else begin
            d_mag = q_r[COORD_WIDTH:0];
        end
        d_s  = e_ctrl.neg ? (SW'(0) - {3'b000, d_mag}) : $signed({3'b000, d_mag});
        m_s  = $signed(e_mul);
        px_s = $signed({{4{e_px[COORD_WIDTH-1]}}, e_px});
        py_s = $signed({{4{e_py[COORD_WIDTH-1]}}, e_py});
        mu_s = $signed({5'b00000, e_mu});
        pm_s = px_s - mu_s;
        qm_s = py_s - mu_s;
        rx = px_s;
        ry = py_s;
        unique case (e_ctrl.kind)
            KIND_X_FLAT: begin
                if (e_ctrl.horiz) begin rx = d_s + mu_s; w = py_s; end
                else begin ry = m_s; w = m_s; end
            end
            KIND_X_STEEP: begin
                if (e_ctrl.horiz) begin rx = m_s + mu_s; w = m_s; end
                else begin ry = d_s; w = pm_s; end
            end
            KIND_Y_FLAT: begin
                if (e_ctrl.horiz) begin rx = d_s; w = qm_s; end
                else begin ry = m_s + mu_s; w = m_s; end
            end
            KIND_Y_STEEP: begin
                if (e_ctrl.horiz) begin rx = m_s; w = m_s; end
                else begin ry = d_s + mu_s; w = px_s; end
            end
            default: begin
                w = '0;
            end
        endcase
    end

    logic                   r_valid;
    logic [COORD_WIDTH-1:0] r_px, r_py, r_w;
    logic                   r_horiz, r_zdiv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= e_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= sat(rx);
        r_py    <= sat(ry);
        r_w     <= sat(w);
        r_horiz <= e_ctrl.horiz;
        // division path: flat with horizontal push, steep with vertical push
        r_zdiv  <= e_ctrl.lam_zero && (e_ctrl.horiz ^ e_ctrl.kind[0]);
    end

    assign o_valid           = r_valid;
    assign o_pushed_x        = r_px;
    assign o_pushed_y        = r_py;
    assign o_weighted_value  = r_w;
    assign o_went_horizontal = r_horiz;
    assign o_zero_divide     = r_zdiv;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a matching start");

    a_horiz_keeps_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_went_horizontal) |-> (o_pushed_y == $past(i_point_y, LAT)))
        else $error("horizontal push changed y");

    a_vert_keeps_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_went_horizontal) |-> (o_pushed_x == $past(i_point_x, LAT)))
        else $error("vertical push changed x");

endmodule

FILE: tb/dual_line_point_push_tb.sv
// Self-checking testbench for dual_line_point_push: directed table, then random words.
// Depends on dlpp_pkg and the dual_line_point_push RTL; predicts results independently.
module dual_line_point_push_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dlpp_pkg::*;

    localparam int  CW        = COORD_WIDTH_DEF;
    localparam int  FB        = FRAC_BITS_DEF;
    localparam int  LATENCY   = CW + FB + 5;
    localparam int  CYCLE_CAP = 400000;
    localparam int  N_RANDOM  = 1750;
    localparam longint ONE_Q  = 64'sd1 <<< FB;
    localparam longint FMASK  = ONE_Q - 1;
    localparam longint BIG    = 64'sd1 <<< CW;
    localparam longint CMAX   = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN   = -(64'sd1 <<< (CW - 1));

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic          horiz;
        logic          zdiv;
    } t_push_result;

    typedef struct packed {
        logic          is_y;
        logic          steep;
        logic [FB:0]   lam;
        logic [CW-2:0] mu;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic          typed;
        t_push_result  res;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_axis_is_y;
    logic          i_angle_is_steep;
    logic [FB:0]   i_slope_param;
    logic [CW-2:0] i_offset_param;
    logic [CW-1:0] i_point_x;
    logic [CW-1:0] i_point_y;
    logic          o_valid;
    logic [CW-1:0] o_pushed_x;
    logic [CW-1:0] o_pushed_y;
    logic [CW-1:0] o_weighted_value;
    logic          o_went_horizontal;
    logic          o_zero_divide;

    t_push_result pending_pushes[$];
    t_push_result typed_pushes[$];
    logic         typed_flags[$];
    int           mismatches;
    int           cycle_cnt;

    dual_line_point_push DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_axis_is_y(i_axis_is_y), .i_angle_is_steep(i_angle_is_steep),
        .i_slope_param(i_slope_param), .i_offset_param(i_offset_param),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .o_valid(o_valid), .o_pushed_x(o_pushed_x), .o_pushed_y(o_pushed_y),
        .o_weighted_value(o_weighted_value), .o_went_horizontal(o_went_horizontal),
        .o_zero_divide(o_zero_divide)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    // exact test a * 2^F >= lam * d
    function automatic logic line_below(longint a, longint d, longint lam);
        longint dh, dl, t, low;
        dh  = d >>> FB;
        dl  = d & FMASK;
        t   = a - lam * dh;
        low = (dl * lam + FMASK) >>> FB;
        return t >= low;
    endfunction

    // lam * a / 2^F, rounded half away from zero
    function automatic longint scale_by_slope(longint a, longint lam);
        longint m, r;
        m = (a < 0) ? -a : a;
        r = (m >>> FB) * lam + (((m & FMASK) * lam + (ONE_Q >>> 1)) >>> FB);
        return (a < 0) ? -r : r;
    endfunction

    // a * 2^F / lam, rounded half away from zero; zero lam saturates unless a is zero
    function automatic longint divide_by_slope(longint a, longint lam, inout logic zdiv);
        longint n, qh, r, r2, q;
        n = (a < 0) ? -a : a;
        if (lam == 0) begin
            zdiv = 1'b1;
            if (n == 0) return 0;
            q = BIG;
        end else begin
            qh = n / lam;
            r  = n % lam;
            if (qh > (BIG >>> FB)) begin
                q = BIG;
            end else begin
                q  = (qh <<< FB) + (r <<< FB) / lam;
                r2 = (r <<< FB) % lam;
                if (2 * r2 >= lam) q++;
            end
        end
        return (a < 0) ? -q : q;
    endfunction

    function automatic t_push_result predict_push(logic is_y, logic steep, logic [FB:0] lam_b,
                                                  logic [CW-2:0] mu_b, logic [CW-1:0] px_b,
                                                  logic [CW-1:0] py_b);
        t_kind        kind;
        longint       lam, mu, px, py, rx, ry, w;
        logic         zdiv, horiz;
        t_push_result res;
        kind = t_kind'({is_y, steep});
        lam  = longint'({1'b0, lam_b});
        mu   = longint'({1'b0, mu_b});
        px   = longint'($signed(px_b));
        py   = longint'($signed(py_b));
        zdiv = 1'b0;
        rx   = px;
        ry   = py;
        case (kind)
            KIND_X_FLAT: begin
                horiz = line_below(py, px - mu, lam);
                if (horiz) begin
                    rx = divide_by_slope(py, lam, zdiv) + mu; w = py;
                end else begin
                    ry = scale_by_slope(px - mu, lam); w = ry;
                end
            end
            KIND_X_STEEP: begin
                horiz = line_below(mu - px, -py, lam);
                if (horiz) begin
                    w = scale_by_slope(py, lam); rx = w + mu;
                end else begin
                    ry = divide_by_slope(px - mu, lam, zdiv); w = px - mu;
                end
            end
            KIND_Y_FLAT: begin
                horiz = line_below(py - mu, px, lam);
                if (horiz) begin
                    rx = divide_by_slope(py - mu, lam, zdiv); w = py - mu;
                end else begin
                    w = scale_by_slope(px, lam); ry = w + mu;
                end
            end
            default: begin
                horiz = line_below(-px, mu - py, lam);
                if (horiz) begin
                    rx = scale_by_slope(py - mu, lam); w = rx;
                end else begin
                    ry = divide_by_slope(px, lam, zdiv) + mu; w = px;
                end
            end
        endcase
        res.x     = CW'(clamp(rx));
        res.y     = CW'(clamp(ry));
        res.w     = CW'(clamp(w));
        res.horiz = horiz;
        res.zdiv  = zdiv;
        return res;
    endfunction

    // words are taken and results checked on the same rising edge
    always @(posedge i_clk) begin
        t_push_result exp_r;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_pushes.size() == 0) begin
                    $error("result with no word outstanding");
                    mismatches++;
                end else begin
                    exp_r = pending_pushes.pop_front();
                    if (o_pushed_x !== exp_r.x) begin
                        $error("pushed_x exp %h got %h", exp_r.x, o_pushed_x); mismatches++;
                    end
                    if (o_pushed_y !== exp_r.y) begin
                        $error("pushed_y exp %h got %h", exp_r.y, o_pushed_y); mismatches++;
                    end
                    if (o_weighted_value !== exp_r.w) begin
                        $error("weighted_value exp %h got %h", exp_r.w, o_weighted_value);
                        mismatches++;
                    end
                    if (o_went_horizontal !== exp_r.horiz) begin
                        $error("went_horizontal exp %b got %b", exp_r.horiz, o_went_horizontal);
                        mismatches++;
                    end
                    if (o_zero_divide !== exp_r.zdiv) begin
                        $error("zero_divide exp %b got %b", exp_r.zdiv, o_zero_divide);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                if (typed_flags.size() != 0 && typed_flags.pop_front())
                    pending_pushes.push_back(typed_pushes.pop_front());
                else
                    pending_pushes.push_back(predict_push(i_axis_is_y, i_angle_is_steep,
                        i_slope_param, i_offset_param, i_point_x, i_point_y));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("dual_line_point_push_tb failed");
            $finish;
        end
    end

    // hold one word on the ports until it is taken; called at a falling edge
    task automatic send_word(t_row r);
        i_axis_is_y      = r.is_y;
        i_angle_is_steep = r.steep;
        i_slope_param    = r.lam;
        i_offset_param   = r.mu;
        i_point_x        = r.px;
        i_point_y        = r.py;
        start            = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1, 2: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row random_row();
        t_row r;
        r.is_y  = 1'($urandom_range(0, 1));
        r.steep = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: r.lam = '0;
            1: r.lam = 17'h10000;
            2: r.lam = (FB+1)'($urandom_range(0, 17'h1ffff));
            default: r.lam = (FB+1)'($urandom_range(1, 17'h10000));
        endcase
        r.mu    = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h3ffff));
        r.px    = rand_coord();
        r.py    = rand_coord();
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    t_row dir_rows [] = '{
        // zero lambda, division by zero saturates high
        '{1'b0, 1'b0, 17'h0, 31'h0, 32'h0, 32'h0001_0000, 1'b1,
          '{32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1}},
        // vertical line x = 0, point left of it, then point right of it
        '{1'b1, 1'b1, 17'h0, 31'h0, 32'hffff_0000, 32'h0, 1'b1,
          '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}},
        '{1'b1, 1'b1, 17'h0, 31'h0, 32'h0001_0000, 32'h0, 1'b1,
          '{32'h0001_0000, 32'h7fff_ffff, 32'h0001_0000, 1'b0, 1'b1}},
        // zero numerator over zero lambda, then mixed edge cases
        '{1'b1, 1'b0, 17'h0, 31'h0, 32'h0, 32'h0, 1'b0, '0},
        '{1'b0, 1'b1, 17'h0, 31'h0, 32'h0, 32'h0, 1'b0, '0},
        '{1'b0, 1'b1, 17'h0, 31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
        '{1'b0, 1'b0, 17'h10000, 31'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 1'b1, 17'h10000, 31'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
        '{1'b1, 1'b0, 17'h1ffff, 31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
        '{1'b1, 1'b1, 17'h1ffff, 31'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
        '{1'b1, 1'b0, 17'h00001, 31'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 1'b0, 17'h00001, 31'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
        '{1'b1, 1'b1, 17'h08000, 31'h0, 32'h0000_0001, 32'hffff_ffff, 1'b0, '0},
        // half lambda (a rounding tie in the second row), then zero numerator over zero lambda
        '{1'b0, 1'b1, 17'h08000, 31'h0, 32'h0000_0003, 32'h0000_0003, 1'b0, '0},
        '{1'b1, 1'b0, 17'h08000, 31'h0, 32'hffff_fffd, 32'hffff_fffd, 1'b0, '0},
        '{1'b1, 1'b0, 17'h0, 31'h0000_0005, 32'h0, 32'h0000_0005, 1'b0, '0}
    };

    initial begin
        int   burst_left;
        t_row r;
        mismatches       = 0;
        cycle_cnt        = 0;
        start            = 1'b0;
        i_axis_is_y      = 1'b0;
        i_angle_is_steep = 1'b0;
        i_slope_param    = '0;
        i_offset_param   = '0;
        i_point_x        = '0;
        i_point_y        = '0;
        i_rst_n          = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            typed_flags.push_back(dir_rows[k].typed);
            typed_pushes.push_back(dir_rows[k].res);
            send_word(dir_rows[k]);
        end
        start = 1'b0;

        burst_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // drain the pipe completely once mid-run
                start = 1'b0;
                while (pending_pushes.size() != 0) @(negedge i_clk);
            end
            if (burst_left == 0) begin
                start = 1'b0;
                if (n < 200 || $urandom_range(0, 3) != 0)
                    repeat ($urandom_range(1, 9)) @(negedge i_clk);
                burst_left = (n < 200) ? 200 : $urandom_range(1, 40);
            end
            burst_left--;
            r = random_row();
            send_word(r);
        end
        start = 1'b0;

        while (pending_pushes.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatches == 0)
            $display("dual_line_point_push_tb passed");
        else
            $display("dual_line_point_push_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
design/dlpp_pkg.sv
design/dlpp_div_cell.sv
design/dlpp_front.sv
design/dual_line_point_push.sv
tb/dual_line_point_push_tb.sv
